// ===== hdl/assert_macros.svh =====
// assertion macros shared by the allocator rtl
// expects signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock outside reset
`define LFRA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication outside reset
`define LFRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication outside reset
`define LFRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lfra_pkg.sv =====
// types, constants and control structs of the lowest free room allocator
// no dependencies
`timescale 1ns / 1ps

package lfra_pkg;

  localparam int ROOMS    = 1024;
  localparam int GUESTS   = 1024;
  localparam int WORD_W   = 32;
  localparam int ROWS     = ROOMS / WORD_W;
  localparam int ROOM_W   = $clog2(ROOMS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int GUEST_W  = $clog2(GUESTS);
  localparam int CNT_W    = 11;
  localparam int ROWLIM_W = CNT_W + 1 - BIT_W;

  localparam int IN_TDATA_W  = ((GUEST_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] NUM_ROOMS_RST = 11'd1024;

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_DEPART = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ARV,
    S_DEP_RD,
    S_DEP_WR
  } state_t;

  // free map port controls
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
  } fm_ctl_t;

  // guest table port controls
  typedef struct packed {
    logic               rd_en;
    logic [GUEST_W-1:0] rd_guest;
    logic               wr_en;
    logic [GUEST_W-1:0] wr_guest;
  } gt_ctl_t;

endpackage

// ===== hdl/lfra_guest_tbl.sv =====
// guest to room table, one synchronous memory with a registered read
// depends on lfra_pkg
`timescale 1ns / 1ps

module lfra_guest_tbl (
  input  logic                          clk,
  input  lfra_pkg::gt_ctl_t             ctl,
  input  logic [lfra_pkg::ROOM_W-1:0]   wr_room,
  output logic [lfra_pkg::ROOM_W-1:0]   rd_room
);

  logic [lfra_pkg::ROOM_W-1:0] mem [lfra_pkg::GUESTS];
  logic [lfra_pkg::ROOM_W-1:0] rd_room_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_guest] <= wr_room;
    end
    if (ctl.rd_en) begin
      rd_room_r <= mem[ctl.rd_guest];
    end
  end

  assign rd_room = rd_room_r;

endmodule

// ===== hdl/lfra_free_map.sv =====
// free map: rows of free bits in a synchronous memory, per-row valid and
// not-full flags, lowest eligible row and lowest free bit search; needs lfra_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfra_free_map (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lfra_pkg::fm_ctl_t            ctl,
  input  lfra_pkg::word_t              wr_word,
  input  logic [lfra_pkg::CNT_W-1:0]   lim,
  output lfra_pkg::word_t              rd_word,
  output logic                         row_ok,
  output logic [lfra_pkg::ROW_W-1:0]   row_sel,
  output logic                         bit_ok,
  output logic [lfra_pkg::BIT_W-1:0]   bit_sel
);

  lfra_pkg::word_t                mem [lfra_pkg::ROWS];
  lfra_pkg::word_t                rd_raw_r;
  logic [lfra_pkg::ROW_W-1:0]     rd_row_r;
  logic                           rd_vld_r;
  logic [lfra_pkg::ROWS-1:0]      row_vld_r;
  logic [lfra_pkg::ROWS-1:0]      nonfull_r;
  logic [lfra_pkg::ROWLIM_W-1:0]  row_lim;
  logic [lfra_pkg::CNT_W:0]       lim_up;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_row] <= wr_word;
    end
    if (ctl.rd_en) begin
      rd_raw_r <= mem[ctl.rd_row];
      rd_row_r <= ctl.rd_row;
    end
  end

  // rows never written read as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      nonfull_r <= '1;
      rd_vld_r  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        row_vld_r[ctl.wr_row] <= 1'b1;
        nonfull_r[ctl.wr_row] <= |wr_word;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= row_vld_r[ctl.rd_row];
      end
    end
  end

  assign rd_word = rd_vld_r ? rd_raw_r : '1;

  // lowest not-full row that holds at least one room below the limit
  assign lim_up  = {1'b0, lim} + (lfra_pkg::CNT_W+1)'(lfra_pkg::WORD_W - 1);
  assign row_lim = lim_up[lfra_pkg::CNT_W:lfra_pkg::BIT_W];

  always_comb begin
    row_ok  = 1'b0;
    row_sel = '0;
    for (int r = lfra_pkg::ROWS - 1; r >= 0; r--) begin
      if (nonfull_r[r] && (lfra_pkg::ROWLIM_W'(r) < row_lim)) begin
        row_ok  = 1'b1;
        row_sel = lfra_pkg::ROW_W'(r);
      end
    end
  end

  // lowest free bit of the read row that is still below the limit
  always_comb begin
    logic [lfra_pkg::ROOM_W-1:0] rm;
    bit_ok  = 1'b0;
    bit_sel = '0;
    rm      = '0;
    for (int b = lfra_pkg::WORD_W - 1; b >= 0; b--) begin
      rm = {rd_row_r, lfra_pkg::BIT_W'(b)};
      if (rd_word[b] && (lfra_pkg::CNT_W'(rm) < lim)) begin
        bit_ok  = 1'b1;
        bit_sel = lfra_pkg::BIT_W'(b);
      end
    end
  end

  `LFRA_ASSERT(a_fm_no_rw_overlap, !(ctl.rd_en && ctl.wr_en), "free map read and write overlap")
  `LFRA_ASSERT_NXT(a_fm_flag_tracks, ctl.wr_en, nonfull_r[$past(ctl.wr_row)] == (|$past(wr_word)), "not-full flag out of step with row")

endmodule

// ===== hdl/lowest_free_room_allocator.sv =====
// top level of the lowest free room allocator: control sequencer, counters,
// config register and output register; uses lfra_pkg, lfra_free_map, lfra_guest_tbl
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
// - in channel: one transaction per event, in_tuser is the kind (0 arrive, 1 depart),
//   in_tdata[9:0] the guest; events must come in time order, departures first
// - out channel: one transaction per event with room (0 on error), occupancy, peak,
//   and full_error in out_tuser
// - cfg channel: num_rooms, always ready; write only while the block is idle;
//   values above 1024 act as 1024
// - sequence: an arrival passes S_ARV, a departure S_DEP_RD then S_DEP_WR; the result is
//   registered into out_tvalid from the write-back state (S_ARV or S_DEP_WR)
// - each event reads the free map (a departure first reads the guest table) and then
//   writes back; one event is in flight at a time, a new one is taken only in S_IDLE
// - a new event is taken while the previous result still waits in the output register;
//   a stalled receiver holds the event in its write-back cycle, no state changes
// - reset: all rooms free, occupancy and peak zero, num_rooms 1024; no clearing pass,
//   per-row valid bits stand in for the free map contents

module lowest_free_room_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfra_pkg::CNT_W-1:0]        cfg_data,     // num_rooms
  // events in
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lfra_pkg::IN_TDATA_W-1:0]   in_tdata,     // guest_id, zero pad
  input  logic                              in_tuser,     // req_type
  // results out
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lfra_pkg::OUT_TDATA_W-1:0]  out_tdata,    // room, occupancy, peak, zero pad
  output logic                              out_tuser     // full_error
);

  lfra_pkg::state_t               state_r, state_nxt;
  logic [lfra_pkg::CNT_W-1:0]     num_rooms_r;
  logic [lfra_pkg::CNT_W-1:0]     busy_r, busy_nxt;
  logic [lfra_pkg::CNT_W-1:0]     peak_r, peak_nxt;
  logic [lfra_pkg::GUEST_W-1:0]   guest_r;
  logic [lfra_pkg::ROW_W-1:0]     arv_row_r;
  logic                           arv_ok_r;
  logic [lfra_pkg::ROOM_W-1:0]    dep_idx_r;
  logic                           out_tvalid_r;
  logic [lfra_pkg::CNT_W-1:0]     out_room_r, out_occ_r, out_peak_r;
  logic                           out_err_r;

  logic [lfra_pkg::CNT_W-1:0]     lim;
  logic                           accept;
  logic                           slot_free;
  logic                           res_vld;
  logic [lfra_pkg::CNT_W-1:0]     res_room;
  logic                           res_err;
  logic [lfra_pkg::ROOM_W-1:0]    arv_idx;

  lfra_pkg::fm_ctl_t              fm_ctl;
  lfra_pkg::word_t                fm_wr_word;
  lfra_pkg::word_t                fm_rd_word;
  logic                           fm_row_ok;
  logic [lfra_pkg::ROW_W-1:0]     fm_row_sel;
  logic                           fm_bit_ok;
  logic [lfra_pkg::BIT_W-1:0]     fm_bit_sel;

  lfra_pkg::gt_ctl_t              gt_ctl;
  logic [lfra_pkg::ROOM_W-1:0]    gt_wr_room;
  logic [lfra_pkg::ROOM_W-1:0]    gt_rd_room;

  lfra_free_map u_free_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fm_ctl),
    .wr_word (fm_wr_word),
    .lim     (lim),
    .rd_word (fm_rd_word),
    .row_ok  (fm_row_ok),
    .row_sel (fm_row_sel),
    .bit_ok  (fm_bit_ok),
    .bit_sel (fm_bit_sel)
  );

  lfra_guest_tbl u_guest_tbl (
    .clk     (clk),
    .ctl     (gt_ctl),
    .wr_room (gt_wr_room),
    .rd_room (gt_rd_room)
  );

  // room count in use, saturated to the built size
  assign lim = (int'(num_rooms_r) > lfra_pkg::ROOMS) ?
               lfra_pkg::CNT_W'(lfra_pkg::ROOMS) : num_rooms_r;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == lfra_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  // result register can take a new transaction this cycle
  assign slot_free = !out_tvalid_r || out_tready;
  assign arv_idx   = {arv_row_r, fm_bit_sel};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfra_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser == lfra_pkg::REQ_DEPART) ? lfra_pkg::S_DEP_RD
                                                         : lfra_pkg::S_ARV;
        end
      end
      lfra_pkg::S_ARV: begin
        if (slot_free) begin
          state_nxt = lfra_pkg::S_IDLE;
        end
      end
      lfra_pkg::S_DEP_RD: begin
        state_nxt = lfra_pkg::S_DEP_WR;
      end
      lfra_pkg::S_DEP_WR: begin
        if (slot_free) begin
          state_nxt = lfra_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lfra_pkg::S_IDLE;
      end
    endcase
  end

  // memory controls, counters and result
  always_comb begin
    fm_ctl     = '0;
    fm_wr_word = fm_rd_word;
    gt_ctl     = '0;
    gt_wr_room = arv_idx;
    busy_nxt   = busy_r;
    peak_nxt   = peak_r;
    res_vld    = 1'b0;
    res_room   = '0;
    res_err    = 1'b0;
    case (state_r)
      lfra_pkg::S_IDLE: begin
        // arrival reads the lowest eligible not-full row, departure reads the guest entry
        if (accept) begin
          if (in_tuser == lfra_pkg::REQ_DEPART) begin
            gt_ctl.rd_en    = 1'b1;
            gt_ctl.rd_guest = in_tdata[lfra_pkg::GUEST_W-1:0];
          end else begin
            fm_ctl.rd_en  = 1'b1;
            fm_ctl.rd_row = fm_row_sel;
          end
        end
      end
      lfra_pkg::S_ARV: begin
        if (slot_free) begin
          res_vld = 1'b1;
          if (arv_ok_r && fm_bit_ok) begin
            fm_ctl.wr_en     = 1'b1;
            fm_ctl.wr_row    = arv_row_r;
            fm_wr_word       = fm_rd_word & ~(lfra_pkg::word_t'(1) << fm_bit_sel);
            gt_ctl.wr_en     = 1'b1;
            gt_ctl.wr_guest  = guest_r;
            busy_nxt         = busy_r + lfra_pkg::CNT_W'(1);
            peak_nxt         = (busy_nxt > peak_r) ? busy_nxt : peak_r;
            res_room         = lfra_pkg::CNT_W'(arv_idx) + lfra_pkg::CNT_W'(1);
          end else begin
            // hotel full
            res_err = 1'b1;
          end
        end
      end
      lfra_pkg::S_DEP_RD: begin
        fm_ctl.rd_en  = 1'b1;
        fm_ctl.rd_row = gt_rd_room[lfra_pkg::ROOM_W-1:lfra_pkg::BIT_W];
      end
      lfra_pkg::S_DEP_WR: begin
        if (slot_free) begin
          res_vld  = 1'b1;
          res_room = lfra_pkg::CNT_W'(dep_idx_r) + lfra_pkg::CNT_W'(1);
          // a room already free changes nothing
          if (!fm_rd_word[dep_idx_r[lfra_pkg::BIT_W-1:0]]) begin
            fm_ctl.wr_en  = 1'b1;
            fm_ctl.wr_row = dep_idx_r[lfra_pkg::ROOM_W-1:lfra_pkg::BIT_W];
            fm_wr_word    = fm_rd_word |
                            (lfra_pkg::word_t'(1) << dep_idx_r[lfra_pkg::BIT_W-1:0]);
            if (busy_r != '0) begin
              busy_nxt = busy_r - lfra_pkg::CNT_W'(1);
            end
          end
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lfra_pkg::S_IDLE;
      num_rooms_r  <= lfra_pkg::NUM_ROOMS_RST;
      busy_r       <= '0;
      peak_r       <= '0;
      out_tvalid_r <= 1'b0;
      arv_ok_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      peak_r  <= peak_nxt;
      if (cfg_valid && cfg_ready) begin
        num_rooms_r <= cfg_data;
      end
      if (accept) begin
        arv_ok_r <= fm_row_ok;
      end
      if (res_vld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      guest_r   <= in_tdata[lfra_pkg::GUEST_W-1:0];
      arv_row_r <= fm_row_sel;
    end
    if (state_r == lfra_pkg::S_DEP_RD) begin
      dep_idx_r <= gt_rd_room;
    end
    if (res_vld) begin
      out_room_r <= res_room;
      out_occ_r  <= busy_nxt;
      out_peak_r <= peak_nxt;
      out_err_r  <= res_err;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(lfra_pkg::OUT_TDATA_W - lfra_pkg::OUT_FIELD_W)'(0),
                       out_peak_r, out_occ_r, out_room_r};
  assign out_tuser  = out_err_r;

  `LFRA_ASSERT(a_busy_le_peak, busy_r <= peak_r, "occupancy above peak")
  `LFRA_ASSERT_IMP(a_err_room_zero, out_tvalid_r && out_err_r, out_room_r == '0, "error result names a room")
  `LFRA_ASSERT_IMP(a_busy_step, $past(rst_n), (busy_r == $past(busy_r)) || (busy_r == $past(busy_r) + lfra_pkg::CNT_W'(1)) || (busy_r == $past(busy_r) - lfra_pkg::CNT_W'(1)), "occupancy moved by more than one")
  `LFRA_ASSERT_IMP(a_wr_in_result_state, fm_ctl.wr_en, (state_r == lfra_pkg::S_ARV) || (state_r == lfra_pkg::S_DEP_WR), "free map written outside write-back")

endmodule
